// ===== rtl/core/spr_exp_pkg.sv =====
package spr_exp_pkg;

    // entry height select codes (attr bits 7:6)
    localparam logic [1:0] HT_ONE    = 2'd0;
    localparam logic [1:0] HT_TWO    = 2'd1;
    localparam logic [1:0] HT_FOUR_A = 2'd2;
    localparam logic [1:0] HT_FOUR_B = 2'd3;

    // screen mirror pivot and piece height
    localparam logic [9:0] FLIP_PIVOT = 10'd240;
    localparam int         PIECE_SHIFT = 4;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic k_zero;
    } t_dp_status;

endpackage

// ===== rtl/core/spr_exp_dp.sv =====
module spr_exp_dp
    import spr_exp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic [7:0]  i_code_byte,
    input  logic [7:0]  i_attr_byte,
    input  logic [7:0]  i_y_byte,
    input  logic [7:0]  i_x_byte,
    input  logic        i_list_last,
    output logic [9:0]  o_tile_code,
    output logic [3:0]  o_palette_color,
    output logic signed [9:0] o_pos_x,
    output logic signed [9:0] o_pos_y,
    output logic        o_mirrored,
    output logic        o_last_piece,
    output logic        o_list_end
);

    logic       r_scr_flip;
    logic [8:0] r_base;
    logic [3:0] r_color;
    logic [9:0] r_sx;
    logic [9:0] r_sy;
    logic       r_lst;
    logic [1:0] r_k;

    logic [9:0] n_sx;
    logic [9:0] n_sy;
    logic [1:0] n_top;
    logic [9:0] w_k16;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_flip <= 1'b0;
        end else if (i_cfg_we) begin
            r_scr_flip <= i_cfg_wdata;
        end
    end

    // unpack entry: signed x, optional mirror, top piece offset
    always_comb begin
        n_sx = {{2{i_attr_byte[4]}}, i_x_byte};
        n_sy = {2'b00, i_y_byte};
        if (r_scr_flip) begin
            n_sx = FLIP_PIVOT - n_sx;
            n_sy = FLIP_PIVOT - n_sy;
        end
        case (i_attr_byte[7:6])
            HT_ONE:    n_top = 2'd0;
            HT_TWO:    n_top = 2'd1;
            HT_FOUR_A: n_top = 2'd3;
            HT_FOUR_B: n_top = 2'd3;
            default:   n_top = 2'd3;
        endcase
    end

    // entry registers and piece offset counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base  <= {i_code_byte[7], i_attr_byte[5], i_code_byte[6:0]};
            r_color <= i_attr_byte[3:0];
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_lst   <= i_list_last;
            r_k     <= n_top;
        end else if (i_cmd.step) begin
            r_k <= r_k - 2'd1;
        end
    end

    // piece fields from current offset
    assign w_k16 = {4'b0000, r_k, {PIECE_SHIFT{1'b0}}};

    assign o_tile_code     = {1'b0, r_base} + {8'd0, r_k};
    assign o_palette_color = r_color;
    assign o_pos_x         = r_sx;
    assign o_pos_y         = r_scr_flip ? (r_sy - w_k16) : (r_sy + w_k16);
    assign o_mirrored      = r_scr_flip;
    assign o_last_piece    = (r_k == 2'd0);
    assign o_list_end      = (r_k == 2'd0) & r_lst;

    assign o_status.k_zero = (r_k == 2'd0);

endmodule

// ===== rtl/core/spr_exp_ctrl.sv =====
module spr_exp_ctrl
    import spr_exp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    logic w_in_xfer;
    logic w_out_xfer;

    assign w_in_xfer  = i_in_valid & r_in_ready;
    assign w_out_xfer = r_out_valid & i_out_ready;

    // datapath commands
    assign o_cmd.load = w_in_xfer;
    assign o_cmd.step = w_out_xfer & ~i_status.k_zero;

    // state and handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state     <= S_EMIT;
                        r_in_ready  <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_xfer && i_status.k_zero) begin
                        r_state     <= S_IDLE;
                        r_in_ready  <= 1'b1;
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/sprite_entry_expander.sv =====
// Sprite list entry expander.
// Input channel (i_in_valid / o_in_ready) takes one four-byte sprite entry
// plus a list-last flag per transfer. Output channel (o_out_valid /
// i_out_ready) gives one piece draw command per transfer: one, two or four
// pieces per entry, highest piece offset first, the final piece marked.
// i_cfg_we writes the screen flip bit from i_cfg_wdata; write it only while idle.
// Timing: the entry is registered at its transfer and its first piece is
// valid the next cycle. Pieces then leave one per cycle while the receiver
// takes them, the piece counter stepping down at each piece transfer.
// A new entry is taken only after the last piece of the current one has
// been transferred.
// When the receiver stalls, the current piece holds on the outputs and the
// piece counter waits.
// Reset (synchronous, active low) clears the screen flip bit, empties the
// block and raises o_in_ready.
module sprite_entry_expander
    import spr_exp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_code_byte,
    input  logic [7:0]  i_attr_byte,
    input  logic [7:0]  i_y_byte,
    input  logic [7:0]  i_x_byte,
    input  logic        i_list_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [9:0]  o_tile_code,
    output logic [3:0]  o_palette_color,
    output logic signed [9:0] o_pos_x,
    output logic signed [9:0] o_pos_y,
    output logic        o_mirrored,
    output logic        o_last_piece,
    output logic        o_list_end
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing of entry load and piece transfers
    spr_exp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // entry unpack, offset counter and piece fields
    spr_exp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_code_byte     (i_code_byte),
        .i_attr_byte     (i_attr_byte),
        .i_y_byte        (i_y_byte),
        .i_x_byte        (i_x_byte),
        .i_list_last     (i_list_last),
        .o_tile_code     (o_tile_code),
        .o_palette_color (o_palette_color),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_mirrored      (o_mirrored),
        .o_last_piece    (o_last_piece),
        .o_list_end      (o_list_end)
    );

endmodule
